// ----- src/bmr_pkg.sv -----
// bmr_pkg: shared types, constants and the span mask helper for the bitmap range set block
// used by bmr_mem, bmr_ctrl and bitmap_range_set
package bmr_pkg;

	localparam int BYTE_W     = 8;
	localparam int BYTE_IDX_W = 7;   // byte index of a set range end: up to 95
	localparam int START_W    = 8;
	localparam int COUNT_W    = 9;
	localparam int RIDX_W     = 5;
	localparam int END_W      = 10;  // start + count, up to 766

	// operation carried in tuser
	localparam logic FN_SET  = 1'b0;
	localparam logic FN_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_RDW,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  rd_en;
		logic [BYTE_IDX_W-1:0] rd_idx;
		logic                  wr_en;
		logic [BYTE_IDX_W-1:0] wr_idx;
		logic [BYTE_W-1:0]     wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              clipped;
	} result_t;

	// bits of one byte covered by the range; lo is start%8, hi is end%8
	function automatic logic [BYTE_W-1:0] span_mask(input logic is_first, input logic is_last,
			input logic [2:0] lo, input logic [2:0] hi);
		logic [BYTE_W-1:0] m;
		m = 8'hFF;
		if (is_first) begin
			m = m & (8'hFF << lo);
		end
		if (is_last) begin
			m = m & (8'hFF >> (3'd0 - hi));
		end
		return m;
	endfunction

endpackage

// ----- src/bmr_mem.sv -----
// bmr_mem: bitmap byte store, one read and one write port, registered read
// per-entry valid bits give the all-zero reset; depends on bmr_pkg
module bmr_mem import bmr_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          req,
	output logic [BYTE_W-1:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [BYTE_W-1:0] rdata_q;
	logic              rvalid_q;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              same_addr;

	assign rd_addr   = req.rd_idx[AW-1:0];
	assign wr_addr   = req.wr_idx[AW-1:0];
	assign same_addr = req.wr_en && (req.wr_idx == req.rd_idx);

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			// write-through when both ports hit the same byte
			rdata_q <= same_addr ? req.wr_data : mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= same_addr || valid_q[rd_addr];
			end
		end
	end

	// a byte never written since reset reads as zero
	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

// ----- src/bmr_ctrl.sv -----
// bmr_ctrl: sequencer that decodes an item and walks the spanned bytes with
// read-modify-write passes over bmr_mem; depends on bmr_pkg
module bmr_ctrl import bmr_pkg::*; #(
	parameter int MAP_BYTES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_func,
	input  logic [START_W-1:0] in_start,
	input  logic [COUNT_W-1:0] in_count,
	input  logic [RIDX_W-1:0]  in_ridx,
	output logic               res_valid,
	input  logic               res_ready,
	output result_t            res,
	output mem_req_t           mem_req,
	input  logic [BYTE_W-1:0]  rd_data
);

	localparam int MapBits  = MAP_BYTES * 8;
	localparam int ClipBits = (MapBits < 1024) ? MapBits : 1023;
	localparam logic [END_W-1:0] CLIP_END = ClipBits[END_W-1:0];

	state_t state_q, state_d;

	logic                  func_q;
	logic                  ridx_ok_q;
	logic [BYTE_IDX_W-1:0] ridx_q;
	logic [BYTE_IDX_W-1:0] first_q;
	logic [BYTE_IDX_W-1:0] last_q;
	logic [BYTE_IDX_W-1:0] b_q;
	logic [2:0]            lo_q;
	logic [2:0]            hi_q;
	logic                  clip_q;
	logic [BYTE_W-1:0]     rdata_q;
	logic                  wb_valid_s2;
	logic [BYTE_IDX_W-1:0] wb_idx_s2;
	logic [BYTE_W-1:0]     wb_mask_s2;

	logic                  accept;
	logic [END_W-1:0]      end_raw;
	logic                  set_clip;
	logic [END_W-1:0]      end_c;
	logic [END_W-1:0]      end_m1;
	logic                  set_empty;
	logic                  ridx_ok;

	// decode of the incoming set range
	assign end_raw   = {2'b00, in_start} + {1'b0, in_count};
	assign set_clip  = (in_count != '0) && (end_raw > CLIP_END);
	assign end_c     = set_clip ? CLIP_END : end_raw;
	assign end_m1    = end_c - 10'd1;
	assign set_empty = (in_count == '0) || ({2'b00, in_start} >= end_c);
	assign ridx_ok   = ({27'd0, in_ridx} < 32'(MAP_BYTES));
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		res_valid       = 1'b0;
		mem_req.rd_en   = 1'b0;
		mem_req.rd_idx  = ridx_q;
		// write-back in the cycle after the read of the same byte
		mem_req.wr_en   = wb_valid_s2;
		mem_req.wr_idx  = wb_idx_s2;
		mem_req.wr_data = rd_data | wb_mask_s2;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FN_READ) begin
						state_d = ST_RD;
					end else if (set_empty) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_RD: begin
				mem_req.rd_en = ridx_ok_q;
				state_d       = ST_RDW;
			end
			ST_RDW: begin
				state_d = ST_DONE;
			end
			ST_WALK: begin
				mem_req.rd_en  = 1'b1;
				mem_req.rd_idx = b_q;
				if (b_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.read_data = rdata_q;
	assign res.clipped   = clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wb_valid_s2 <= 1'b0;
		end else begin
			state_q     <= state_d;
			wb_valid_s2 <= (state_q == ST_WALK);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= in_func;
			ridx_ok_q <= ridx_ok;
			ridx_q    <= {2'b00, in_ridx};
			first_q   <= {2'b00, in_start[7:3]};
			last_q    <= end_m1[9:3];
			b_q       <= {2'b00, in_start[7:3]};
			lo_q      <= in_start[2:0];
			hi_q      <= end_c[2:0];
			clip_q    <= (in_func == FN_READ) ? 1'b0 : set_clip;
			rdata_q   <= '0;
		end else if (state_q == ST_WALK) begin
			b_q <= b_q + 7'd1;
		end
		if (state_q == ST_RDW) begin
			rdata_q <= ridx_ok_q ? rd_data : '0;
		end
		wb_idx_s2  <= b_q;
		wb_mask_s2 <= span_mask(b_q == first_q, b_q == last_q, lo_q, hi_q);
	end

	a_wb_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_s2 |-> (wb_idx_s2 <= last_q) && (wb_idx_s2 >= first_q))
		else $error("write-back outside the set range");

	a_no_accept_during_wb: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !wb_valid_s2)
		else $error("new word taken while a write-back is pending");

	a_drain_has_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> wb_valid_s2)
		else $error("drain without the last write-back");

	a_read_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (func_q == FN_READ)) |-> !res.clipped)
		else $error("clip flag on a read result");

	a_set_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (func_q == FN_SET)) |-> (res.read_data == '0))
		else $error("nonzero data on a set result");

endmodule

// ----- src/bitmap_range_set.sv -----
// bitmap_range_set: top level, stream ports, output register, sequencer and byte store
// depends on bmr_pkg, bmr_ctrl and bmr_mem
//
// channel  | dir | fields (lsb first)
// s_*      | in  | tuser: func; tdata: start_bit[7:0], bit_count[16:8], read_index[21:17]
// m_*      | out | tdata: read_data[7:0], clipped[8]
//
// read: read and wait states, then the result; set: walks the spanned bytes, then drains;
// zero or empty set: straight to the result. the walk does one read-modify-write per byte
// through the single write port of the byte store, one item at a time.
// reset clears per-byte valid bits at once; no clearing pass is needed.
// a finished result waits in the output register while the next word is taken.
module bitmap_range_set import bmr_pkg::*; #(
	parameter int MAP_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // start_bit, bit_count, read_index, zero pad
	input  logic [0:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data, clipped, zero pad
);

	localparam int Depth = (MAP_BYTES < 96) ? MAP_BYTES : 96;

	mem_req_t          mem_req;
	logic [BYTE_W-1:0] rd_data;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	logic              m_valid_q;
	result_t           m_res_q;

	bmr_ctrl #(
		.MAP_BYTES(MAP_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tuser[0]),
		.in_start (s_tdata[7:0]),
		.in_count (s_tdata[16:8]),
		.in_ridx  (s_tdata[21:17]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_req  (mem_req),
		.rd_data  (rd_data)
	);

	bmr_mem #(
		.DEPTH(Depth)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rd_data(rd_data)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_res_q.clipped, m_res_q.read_data};

endmodule
